// ----- src/dbca_pkg.sv -----
// ----------------------------------------------------------------------------
// dbca_pkg: shared types and constants for the button coordinate adjuster
// Register indexes, reset values, field widths and the per-button status
// struct that the debounce lanes hand to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbca_pkg;

  // Fixed geometry
  localparam int NumButtons = 4;
  localparam int LevelW     = 4;
  localparam int HoldW      = 8;
  localparam int StepW      = 16;
  localparam int BoundW     = 24;
  localparam int OutW       = 24;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LAT_LOW    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LAT_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LON_LOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LON_HIGH   = 3'd5;

  // Button roles
  localparam int BtnLatDown = 0;
  localparam int BtnLatUp   = 1;
  localparam int BtnLonDown = 2;
  localparam int BtnLonUp   = 3;

  // Reset values
  localparam logic [HoldW-1:0]  HoldTicksRst = 8'd10;
  localparam logic [StepW-1:0]  StepSizeRst  = 16'd10;
  localparam logic [BoundW-1:0] LatLowRst    = 24'd1512980;
  localparam logic [BoundW-1:0] LatHighRst   = 24'd1522980;
  localparam logic [BoundW-1:0] LonLowRst    = 24'd5272355;
  localparam logic [BoundW-1:0] LonHighRst   = 24'd5282355;
  localparam logic [BoundW-1:0] LatCoordRst  = 24'd1522980;
  localparam logic [BoundW-1:0] LonCoordRst  = 24'd5272355;

  // Per-button status after the current tick
  typedef struct packed {
    logic pressed;  // debounced press held
    logic fire;     // first tick of this press: step the coordinate
  } lane_status_t;

endpackage

`default_nettype wire

// ----- src/debounced_button_coordinate_adjust.sv -----
// ----------------------------------------------------------------------------
// debounced_button_coordinate_adjust: four-button debounced coordinate stepper
// Debounces four button levels per tick and steps latitude and longitude
// within configurable bounds on the first tick of each press.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | request   | in_valid_i/in_stall_o | button_levels_i
//  out     | result    | out_valid_o/out_stall_i | lat_value_o, lon_value_o,
//          |           |                       | pressed_mask_o
//  cfg     | write     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
//  One request per cycle sustained while no result is stalled; out_valid_o
//  follows the accepting edge through the input register, then the result
//  register. The debounce lanes and both steppers are combinational between
//  the input register and the result register.
//  Reset restores all registers but the data ones and clears the lanes; no clearing pass.
//  A stalled result holds; the input register still takes one more request,
//  then in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module debounced_button_coordinate_adjust #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [dbca_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [dbca_pkg::CfgDataW-1:0]      cfg_data_i,
  // input requests
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [dbca_pkg::LevelW-1:0]        button_levels_i,
  // results
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [dbca_pkg::OutW-1:0]          lat_value_o,
  output logic      [dbca_pkg::OutW-1:0]          lon_value_o,
  output logic      [dbca_pkg::LevelW-1:0]        pressed_mask_o
);

  localparam int WideW = (COORD_BITS > dbca_pkg::OutW) ? COORD_BITS : dbca_pkg::OutW;
  localparam logic [COORD_BITS-1:0] LatRst = COORD_BITS'(dbca_pkg::LatCoordRst);
  localparam logic [COORD_BITS-1:0] LonRst = COORD_BITS'(dbca_pkg::LonCoordRst);

  // Configuration registers
  logic [dbca_pkg::HoldW-1:0]  hold_ticks_q;
  logic [dbca_pkg::StepW-1:0]  step_size_q;
  logic [dbca_pkg::BoundW-1:0] lat_low_q, lat_high_q, lon_low_q, lon_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= dbca_pkg::HoldTicksRst;
      step_size_q  <= dbca_pkg::StepSizeRst;
      lat_low_q    <= dbca_pkg::LatLowRst;
      lat_high_q   <= dbca_pkg::LatHighRst;
      lon_low_q    <= dbca_pkg::LonLowRst;
      lon_high_q   <= dbca_pkg::LonHighRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbca_pkg::REG_HOLD_TICKS: hold_ticks_q <= cfg_data_i[dbca_pkg::HoldW-1:0];
        dbca_pkg::REG_STEP_SIZE:  step_size_q  <= cfg_data_i[dbca_pkg::StepW-1:0];
        dbca_pkg::REG_LAT_LOW:    lat_low_q    <= cfg_data_i;
        dbca_pkg::REG_LAT_HIGH:   lat_high_q   <= cfg_data_i;
        dbca_pkg::REG_LON_LOW:    lon_low_q    <= cfg_data_i;
        dbca_pkg::REG_LON_HIGH:   lon_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and input register
  logic                          s1_valid_q;
  logic [dbca_pkg::LevelW-1:0]   s1_levels_q;
  logic                          out_ready;
  logic                          s1_adv;
  logic                          in_acc;

  assign out_ready  = ~out_valid_o | ~out_stall_i;
  assign s1_adv     = s1_valid_q & out_ready;
  assign in_stall_o = s1_valid_q & ~out_ready;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_levels_q <= button_levels_i;
    end
  end

  // Debounce lanes
  dbca_pkg::lane_status_t        lane_st [dbca_pkg::NumButtons];
  logic [dbca_pkg::LevelW-1:0]   mask_d;

  for (genvar k = 0; k < dbca_pkg::NumButtons; k++) begin : g_lane
    dbca_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (s1_adv),
      .level_i      (s1_levels_q[k]),
      .hold_ticks_i (hold_ticks_q),
      .status_o     (lane_st[k])
    );
    assign mask_d[k] = lane_st[k].pressed;
  end

  // Coordinate steppers
  logic [COORD_BITS-1:0] lat_d, lon_d;
  logic [WideW-1:0]      lat_w, lon_w;

  dbca_coord #(
    .CoordBits (COORD_BITS),
    .ResetVal  (LatRst)
  ) u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_adv),
    .dn_i    (lane_st[dbca_pkg::BtnLatDown].fire),
    .up_i    (lane_st[dbca_pkg::BtnLatUp].fire),
    .step_i  (step_size_q),
    .low_i   (lat_low_q),
    .high_i  (lat_high_q),
    .value_o (lat_d)
  );

  dbca_coord #(
    .CoordBits (COORD_BITS),
    .ResetVal  (LonRst)
  ) u_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_adv),
    .dn_i    (lane_st[dbca_pkg::BtnLonDown].fire),
    .up_i    (lane_st[dbca_pkg::BtnLonUp].fire),
    .step_i  (step_size_q),
    .low_i   (lon_low_q),
    .high_i  (lon_high_q),
    .value_o (lon_d)
  );

  assign lat_w = WideW'(lat_d);
  assign lon_w = WideW'(lon_d);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lat_value_o    <= lat_w[dbca_pkg::OutW-1:0];
      lon_value_o    <= lon_w[dbca_pkg::OutW-1:0];
      pressed_mask_o <= mask_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/dbca_lane.sv -----
// ----------------------------------------------------------------------------
// dbca_lane: debounce lane for one button
// Saturating hold counter plus pressed and acted flags. Reports the status
// after the tick in flight and commits it when the tick advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbca_lane (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            level_i,
  input  wire logic [dbca_pkg::HoldW-1:0]      hold_ticks_i,
  output dbca_pkg::lane_status_t               status_o
);

  logic [dbca_pkg::HoldW-1:0] cnt_q, cnt_d;
  logic                       pressed_q, pressed_d;
  logic                       acted_q, acted_d;

  // Next state for this tick
  always_comb begin
    cnt_d     = cnt_q;
    pressed_d = pressed_q;
    acted_d   = acted_q;
    if (!level_i) begin
      cnt_d     = '0;
      pressed_d = 1'b0;
      acted_d   = 1'b0;
    end else begin
      if (cnt_q < hold_ticks_i) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (cnt_d >= hold_ticks_i) begin
        pressed_d = 1'b1;
      end
      acted_d = acted_q | pressed_d;
    end
  end

  assign status_o.pressed = pressed_d;
  assign status_o.fire    = pressed_d & ~acted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pressed_q <= 1'b0;
      acted_q   <= 1'b0;
    end else if (en_i) begin
      cnt_q     <= cnt_d;
      pressed_q <= pressed_d;
      acted_q   <= acted_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/dbca_coord.sv -----
// ----------------------------------------------------------------------------
// dbca_coord: bounded coordinate stepper
// Holds one coordinate. A down step (applied first) and then an up step,
// each taken only while the value is strictly inside its bound.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbca_coord #(
  parameter int                   CoordBits = 24,
  parameter logic [CoordBits-1:0] ResetVal  = '0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          dn_i,
  input  wire logic                          up_i,
  input  wire logic [dbca_pkg::StepW-1:0]    step_i,
  input  wire logic [dbca_pkg::BoundW-1:0]   low_i,
  input  wire logic [dbca_pkg::BoundW-1:0]   high_i,
  output logic      [CoordBits-1:0]          value_o
);

  localparam int CmpW = (CoordBits > dbca_pkg::BoundW) ? CoordBits : dbca_pkg::BoundW;

  logic [CoordBits-1:0] coord_q, coord_d;
  logic [CoordBits-1:0] after_dn;
  logic [CoordBits-1:0] step_ext;

  assign step_ext = CoordBits'(step_i);

  // Down step, then up step on the result (wraps modulo the register width)
  always_comb begin
    after_dn = coord_q;
    if (dn_i && (CmpW'(coord_q) > CmpW'(low_i))) begin
      after_dn = coord_q - step_ext;
    end
    coord_d = after_dn;
    if (up_i && (CmpW'(after_dn) < CmpW'(high_i))) begin
      coord_d = after_dn + step_ext;
    end
  end

  assign value_o = coord_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= ResetVal;
    end else if (en_i) begin
      coord_q <= coord_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/dbca_checker.sv -----
// ----------------------------------------------------------------------------
// dbca_checker: port-level checks for the button coordinate adjuster
// Watches the top-level ports; a coordinate may only move on a result whose
// pressed mask shows a button of that axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbca_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic                               in_stall_o,
  input  wire logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  input  wire logic [dbca_pkg::OutW-1:0]          lat_value_o,
  input  wire logic [dbca_pkg::OutW-1:0]          lon_value_o,
  input  wire logic [dbca_pkg::LevelW-1:0]        pressed_mask_o
);

  logic                        seen_q;
  logic [dbca_pkg::OutW-1:0]   last_lat_q, last_lon_q;
  logic                        out_acc;

  assign out_acc = out_valid_o & ~out_stall_i;

  // Track the last delivered coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_lat_q <= '0;
      last_lon_q <= '0;
    end else if (out_acc) begin
      seen_q     <= 1'b1;
      last_lat_q <= lat_value_o;
      last_lon_q <= lon_value_o;
    end
  end

  // Input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("in_stall_o high without a stalled result");

  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // An accepted request is followed by a valid result
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("accepted request produced no result");

  // Latitude moves only on a tick with a latitude button pressed
  a_lat_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seen_q && !pressed_mask_o[dbca_pkg::BtnLatDown]
     && !pressed_mask_o[dbca_pkg::BtnLatUp]) |-> (lat_value_o == last_lat_q))
    else $error("latitude changed without a latitude press");

  // Longitude moves only on a tick with a longitude button pressed
  a_lon_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seen_q && !pressed_mask_o[dbca_pkg::BtnLonDown]
     && !pressed_mask_o[dbca_pkg::BtnLonUp]) |-> (lon_value_o == last_lon_q))
    else $error("longitude changed without a longitude press");

endmodule

bind debounced_button_coordinate_adjust dbca_checker u_dbca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .lat_value_o    (lat_value_o),
  .lon_value_o    (lon_value_o),
  .pressed_mask_o (pressed_mask_o)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for debounced_button_coordinate_adjust
// Feeds button-level requests through a valid/stall driver and checks every
// result against a cycle-free model of the debounce lanes and the two
// coordinate steppers. It also walks the configuration through several
// settings, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int      CoordBits = 24;
  localparam longint  TimeoutNs = 64'd5_000_000;

  // Indexes with no register behind them
  localparam logic [dbca_pkg::CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [dbca_pkg::CfgIdxW-1:0] RegSpareB = 3'd7;

  typedef struct packed {
    logic [dbca_pkg::LevelW-1:0] levels;
    logic [dbca_pkg::OutW-1:0]   lat;
    logic [dbca_pkg::OutW-1:0]   lon;
    logic [dbca_pkg::LevelW-1:0] mask;
  } coord_entry_t;

  // DUT signals
  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [dbca_pkg::CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [dbca_pkg::CfgDataW-1:0] cfg_data_i      = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [dbca_pkg::LevelW-1:0]   button_levels_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic [dbca_pkg::OutW-1:0]     lat_value_o;
  logic [dbca_pkg::OutW-1:0]     lon_value_o;
  logic [dbca_pkg::LevelW-1:0]   pressed_mask_o;

  // Bench state
  logic [dbca_pkg::LevelW-1:0] level_q[$];
  coord_entry_t                pending_coords[$];
  bit                          level_taken;
  bit                          no_idle;
  bit                          rx_hold_req;
  int                          rx_hold_left;
  int                          fail_cnt;

  // Model copy of the registers
  logic [dbca_pkg::HoldW-1:0]  m_hold;
  logic [dbca_pkg::StepW-1:0]  m_step;
  logic [dbca_pkg::BoundW-1:0] m_lat_low, m_lat_high, m_lon_low, m_lon_high;
  logic [dbca_pkg::HoldW-1:0]  m_cnt[dbca_pkg::NumButtons];
  logic                        m_pressed[dbca_pkg::NumButtons];
  logic                        m_acted[dbca_pkg::NumButtons];
  logic [CoordBits-1:0]        m_lat, m_lon;

  debounced_button_coordinate_adjust #(
    .COORD_BITS(CoordBits)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_levels_i(button_levels_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lat_value_o    (lat_value_o),
    .lon_value_o    (lon_value_o),
    .pressed_mask_o (pressed_mask_o)
  );

  always #6 clk_i = ~clk_i;

  // Register write as seen by the model; unknown indexes are dropped
  function automatic void apply_cfg(input logic [dbca_pkg::CfgIdxW-1:0] idx,
                                    input logic [dbca_pkg::CfgDataW-1:0] d);
    case (idx)
      dbca_pkg::REG_HOLD_TICKS: m_hold     = d[dbca_pkg::HoldW-1:0];
      dbca_pkg::REG_STEP_SIZE:  m_step     = d[dbca_pkg::StepW-1:0];
      dbca_pkg::REG_LAT_LOW:    m_lat_low  = d[dbca_pkg::BoundW-1:0];
      dbca_pkg::REG_LAT_HIGH:   m_lat_high = d[dbca_pkg::BoundW-1:0];
      dbca_pkg::REG_LON_LOW:    m_lon_low  = d[dbca_pkg::BoundW-1:0];
      dbca_pkg::REG_LON_HIGH:   m_lon_high = d[dbca_pkg::BoundW-1:0];
      default: ;
    endcase
  endfunction

  // One tick of the debounce lanes, buttons in order 0 to 3
  function automatic coord_entry_t predict_tick(input logic [dbca_pkg::LevelW-1:0] lv);
    coord_entry_t r;
    r.levels = lv;
    r.mask   = '0;
    for (int k = 0; k < dbca_pkg::NumButtons; k++) begin
      if (!lv[k]) begin
        m_cnt[k]     = '0;
        m_pressed[k] = 1'b0;
        m_acted[k]   = 1'b0;
      end else begin
        if (m_cnt[k] < m_hold) m_cnt[k] = m_cnt[k] + 1'b1;
        if (m_cnt[k] >= m_hold) m_pressed[k] = 1'b1;
      end
      if (m_pressed[k] && !m_acted[k]) begin
        m_acted[k] = 1'b1;
        case (k)
          dbca_pkg::BtnLatDown: if (m_lat > m_lat_low)  m_lat = m_lat - m_step;
          dbca_pkg::BtnLatUp:   if (m_lat < m_lat_high) m_lat = m_lat + m_step;
          dbca_pkg::BtnLonDown: if (m_lon > m_lon_low)  m_lon = m_lon - m_step;
          dbca_pkg::BtnLonUp:   if (m_lon < m_lon_high) m_lon = m_lon + m_step;
          default: ;
        endcase
      end
      if (m_pressed[k]) r.mask[k] = 1'b1;
    end
    r.lat = m_lat[dbca_pkg::OutW-1:0];
    r.lon = m_lon[dbca_pkg::OutW-1:0];
    return r;
  endfunction

  // Bound a few steps away from the current coordinate
  function automatic logic [dbca_pkg::BoundW-1:0] near_coord(
      input logic [dbca_pkg::BoundW-1:0] c,
      input logic [dbca_pkg::StepW-1:0]  s,
      input bit up);
    logic [dbca_pkg::BoundW-1:0] span;
    span = dbca_pkg::BoundW'(s * $urandom_range(0, 5));
    return up ? c + span : c - span;
  endfunction

  // Request driver: a payload holds until taken; idle only between requests
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || level_taken)) begin
      if (level_q.size() != 0 && (no_idle || $urandom_range(99) >= 12)) begin
        in_valid_i      <= 1'b1;
        button_levels_i <= level_q[0];
      end else begin
        in_valid_i      <= 1'b0;
      end
    end
  end

  // Result stall: random, or one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = 200;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < 12);
    end
  end

  // Monitor: check results in order, predict on each accepted request
  always @(posedge clk_i) begin : monitor
    coord_entry_t want;
    level_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_coords.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: lat %h lon %h mask %h",
                     lat_value_o, lon_value_o, pressed_mask_o);
        end else begin
          want = pending_coords.pop_front();
          if (lat_value_o !== want.lat || lon_value_o !== want.lon ||
              pressed_mask_o !== want.mask) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"mismatch on levels %h: exp lat %h lon %h mask %h, ",
                        "got lat %h lon %h mask %h"},
                       want.levels, want.lat, want.lon, want.mask,
                       lat_value_o, lon_value_o, pressed_mask_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = predict_tick(button_levels_i);
        pending_coords.push_back(want);
        level_q.delete(0);
        level_taken = 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [dbca_pkg::CfgIdxW-1:0] idx,
                           input logic [dbca_pkg::CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    apply_cfg(idx, d);
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [dbca_pkg::CfgDataW-1:0] hold,
                            input logic [dbca_pkg::CfgDataW-1:0] stp,
                            input logic [dbca_pkg::CfgDataW-1:0] lat_lo,
                            input logic [dbca_pkg::CfgDataW-1:0] lat_hi,
                            input logic [dbca_pkg::CfgDataW-1:0] lon_lo,
                            input logic [dbca_pkg::CfgDataW-1:0] lon_hi);
    cfg_write(dbca_pkg::REG_HOLD_TICKS, hold);
    cfg_write(dbca_pkg::REG_STEP_SIZE, stp);
    cfg_write(dbca_pkg::REG_LAT_LOW, lat_lo);
    cfg_write(dbca_pkg::REG_LAT_HIGH, lat_hi);
    cfg_write(dbca_pkg::REG_LON_LOW, lon_lo);
    cfg_write(dbca_pkg::REG_LON_HIGH, lon_hi);
    cfg_done();
  endtask

  // Bounds placed a few steps around where the coordinates are now
  task automatic config_near(input logic [dbca_pkg::HoldW-1:0] hold,
                             input logic [dbca_pkg::StepW-1:0] stp,
                             input logic [dbca_pkg::StepW-1:0] spread);
    set_config(hold, stp, near_coord(m_lat, spread, 1'b0), near_coord(m_lat, spread, 1'b1),
               near_coord(m_lon, spread, 1'b0), near_coord(m_lon, spread, 1'b1));
  endtask

  // Sender pause: nothing queued and every result back, then the latency
  task automatic wait_drained();
    while (level_q.size() != 0 || pending_coords.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Queue n level nibbles, the first one in the top nibble used
  task automatic push_nibbles(input logic [39:0] seq, input int n);
    for (int i = n - 1; i >= 0; i--) level_q.push_back(seq[4*i +: 4]);
  endtask

  task automatic push_hold(input logic [dbca_pkg::LevelW-1:0] lv, input int n);
    repeat (n) level_q.push_back(lv);
  endtask

  // Mostly full presses with random buttons, some short blips and noise
  task automatic run_random(input int n);
    int made;
    int len;
    logic [dbca_pkg::LevelW-1:0] pat;
    made = 0;
    while (made < n) begin
      pat = 4'($urandom_range(1, 15));
      case ($urandom_range(0, 9))
        0: begin
          level_q.push_back(4'($urandom));
          made++;
        end
        1: begin
          // released before the press registers, unless the hold is one or less
          len = (m_hold > 1) ? $urandom_range(1, m_hold - 1) : 1;
          push_hold(pat, len);
          level_q.push_back('0);
          made += len + 1;
        end
        default: begin
          len = int'(m_hold) + $urandom_range(0, 3);
          if (len == 0) len = 1;
          push_hold(pat, len);
          made += len;
          // partial release, then all up
          len = $urandom_range(0, 3);
          push_hold(pat & 4'($urandom), len);
          made += len;
          len = $urandom_range(1, 2);
          push_hold('0, len);
          made += len;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [dbca_pkg::StepW-1:0] stp;
    no_idle     = 1'b0;
    rx_hold_req = 1'b0;
    fail_cnt    = 0;

    // Model reset state
    m_hold     = dbca_pkg::HoldTicksRst;
    m_step     = dbca_pkg::StepSizeRst;
    m_lat_low  = dbca_pkg::LatLowRst;
    m_lat_high = dbca_pkg::LatHighRst;
    m_lon_low  = dbca_pkg::LonLowRst;
    m_lon_high = dbca_pkg::LonHighRst;
    for (int k = 0; k < dbca_pkg::NumButtons; k++) begin
      m_cnt[k]     = '0;
      m_pressed[k] = 1'b0;
      m_acted[k]   = 1'b0;
    end
    m_lat = dbca_pkg::LatCoordRst;
    m_lon = dbca_pkg::LonCoordRst;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero hold: pressed on the first high tick; all four at once shows
    // the in-order handling. Writes to spare indexes must be dropped.
    cfg_write(dbca_pkg::REG_HOLD_TICKS, '0);
    cfg_write(RegSpareA, 24'hFFFFFF);
    cfg_write(RegSpareB, 24'hFFFFFF);
    cfg_write(RegSpareB, '0);
    cfg_done();
    push_nibbles(40'hFF013_04C0, 9);
    wait_drained();

    // Oversized writes get masked; held buttons saturate the counter
    cfg_write(dbca_pkg::REG_HOLD_TICKS, 24'hFFFF02);
    cfg_write(dbca_pkg::REG_STEP_SIZE, 24'hAB0003);
    cfg_done();
    push_nibbles(40'h22220_8990, 9);
    wait_drained();

    // Zero step
    cfg_write(dbca_pkg::REG_STEP_SIZE, '0);
    cfg_done();
    push_nibbles(40'h110, 3);
    wait_drained();

    // Coordinate sitting exactly on both bounds: no step either way
    cfg_write(dbca_pkg::REG_STEP_SIZE, 24'd5);
    cfg_write(dbca_pkg::REG_LAT_LOW, m_lat);
    cfg_write(dbca_pkg::REG_LAT_HIGH, m_lat);
    cfg_done();
    push_nibbles(40'h330, 3);

    // Random phases, each under its own setting
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      no_idle = (p == 1);
      stp = 16'($urandom_range(1, 1000));
      case (p)
        0: set_config(dbca_pkg::HoldTicksRst, dbca_pkg::StepSizeRst, dbca_pkg::LatLowRst,
                      dbca_pkg::LatHighRst, dbca_pkg::LonLowRst, dbca_pkg::LonHighRst);
        1: config_near(8'd1, 16'($urandom_range(1, 64)), stp);
        2: config_near('0, 16'($urandom), 16'($urandom));
        3: set_config(8'hFF, 16'hFFFF, '0, 24'hFFFFFF, 24'hFFFFFF, '0);
        4: set_config('0, 16'hFFFF, '0, 24'hFFFFFF, '0, 24'hFFFFFF);
        5: config_near(8'($urandom_range(2, 6)), '0, 16'd7);
        default: config_near(8'($urandom_range(1, 12)), stp, stp);
      endcase
      case (p)
        2: begin
          // receiver holds off while requests keep coming
          rx_hold_req = 1'b1;
          run_random(200);
        end
        3: run_random(520);
        4: begin
          // walk both coordinates down past zero, then both up past the top
          repeat (90) push_nibbles(40'h50, 2);
          repeat (30) push_nibbles(40'hA0, 2);
        end
        5: run_random(150);
        6: run_random(340);
        default: run_random(260);
      endcase
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("debounced_button_coordinate_adjust verification clean");
    end else begin
      $display("debounced_button_coordinate_adjust verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("debounced_button_coordinate_adjust verification failed");
    $finish;
  end

endmodule
